// ----- sv/gle_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gle_pkg - shared types and constants of the GIF LZW encoder
// Code token and table access formats used between the encoder's modules.
// ----------------------------------------------------------------------------
package gle_pkg;

	localparam int MAX_CODE_BITS_DEF = 12;
	localparam int SYMBOL_BITS_DEF   = 8;

	localparam int CODE_W      = 12;
	localparam int SYM_W       = 8;
	localparam int ADDR_W_MAX  = CODE_W + SYM_W;
	localparam int EPOCH_BITS  = 10;
	localparam int DATA_W_MAX  = EPOCH_BITS + CODE_W;
	localparam int CW_W        = 4;
	localparam int BYTE_BITS   = 8;
	localparam int QUEUE_DEPTH = 8;
	localparam int PUSH_MAX    = 4;
	localparam int PUSH_CNT_W  = $clog2(PUSH_MAX + 1);

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [CW_W-1:0]   width;
		logic              fin;
	} tok_t;

	typedef struct packed {
		logic [PUSH_CNT_W-1:0]   cnt;
		tok_t [PUSH_MAX-1:0]     tok;
	} tok_push_t;

	typedef struct packed {
		logic                  rd_en;
		logic [ADDR_W_MAX-1:0] rd_addr;
		logic                  wr_en;
		logic [ADDR_W_MAX-1:0] wr_addr;
		logic [DATA_W_MAX-1:0] wr_data;
	} tbl_req_t;

endpackage

// ----- sv/gle_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gle_table - string table memory
// Single-port-write, single-port-read synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module gle_table
	import gle_pkg::*;
#(
	parameter int ADDR_W = ADDR_W_MAX,
	parameter int DATA_W = DATA_W_MAX
) (
	input  logic              clk,
	input  tbl_req_t          req,
	output logic [DATA_W-1:0] rd_data
);

	localparam int DEPTH = 1 << ADDR_W;

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr[ADDR_W-1:0]] <= req.wr_data[DATA_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data <= mem_q[req.rd_addr[ADDR_W-1:0]];
		end
	end

endmodule

// ----- sv/gle_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gle_core - LZW dictionary control
// Looks up (prefix, pixel) in the string table, decides hit or miss, writes
// new entries back, tracks code width and table epoch, and issues code tokens.
// ----------------------------------------------------------------------------
module gle_core
	import gle_pkg::*;
#(
	parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF,
	parameter int SYMBOL_BITS   = SYMBOL_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [7:0]                   s_tdata,
	input  logic [1:0]                   s_tuser,
	output tbl_req_t                     tbl_req,
	input  logic [EPOCH_BITS+MAX_CODE_BITS-1:0] tbl_rd_data,
	output tok_push_t                    push,
	input  logic                         room
);

	localparam int ADDR_W = MAX_CODE_BITS + SYMBOL_BITS;
	localparam int DATA_W = EPOCH_BITS + MAX_CODE_BITS;
	localparam int NF_W   = MAX_CODE_BITS + 1;

	localparam logic [1:0] REQ_PIXEL = 2'd0;
	localparam logic [1:0] REQ_LAST  = 2'd1;
	localparam logic [1:0] REQ_EMPTY = 2'd2;

	localparam logic [CODE_W-1:0] CLEAR_CODE = CODE_W'(1 << SYMBOL_BITS);
	localparam logic [CODE_W-1:0] END_CODE   = CODE_W'((1 << SYMBOL_BITS) + 1);
	localparam logic [CODE_W-1:0] HDR_CODE   = CODE_W'(SYMBOL_BITS);
	localparam logic [NF_W-1:0]   FIRST_FREE = NF_W'((1 << SYMBOL_BITS) + 2);
	localparam logic [NF_W-1:0]   CODE_LIMIT = NF_W'(1 << MAX_CODE_BITS);
	localparam logic [CW_W-1:0]   START_W    = CW_W'(SYMBOL_BITS + 1);
	localparam logic [CW_W-1:0]   MAX_W      = CW_W'(MAX_CODE_BITS);
	localparam logic [CW_W-1:0]   HDR_W      = CW_W'(BYTE_BITS);
	localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);

	typedef enum logic [2:0] {
		ST_SWEEP  = 3'b001,
		ST_ACCEPT = 3'b010,
		ST_DECIDE = 3'b100
	} state_t;

	state_t                   state_q;
	logic [ADDR_W-1:0]        sweep_q;
	logic [MAX_CODE_BITS-1:0] prefix_q;
	logic [NF_W-1:0]          nf_q;
	logic [CW_W-1:0]          cw_q;
	logic                     in_frame_q;
	logic [EPOCH_BITS-1:0]    epoch_q;

	logic [1:0]               req_s1;
	logic [SYMBOL_BITS-1:0]   sym_s1;
	logic [ADDR_W-1:0]        idx_s1;

	logic                     accept;
	logic                     hit;
	logic [MAX_CODE_BITS-1:0] rcode;
	logic [MAX_CODE_BITS-1:0] sym_ext;
	logic [NF_W-1:0]          lim_v;

	logic [CW_W-1:0]          w_v;
	logic [NF_W-1:0]          nf_v;
	logic [MAX_CODE_BITS-1:0] pf_v;
	logic                     inf_v;
	logic                     clr_v;
	logic                     wr_v;
	logic [PUSH_CNT_W-1:0]    n_v;
	tok_t [PUSH_MAX-1:0]      tok_v;
	logic                     wrap;

	function automatic tok_t mk_tok(logic [CODE_W-1:0] c, logic [CW_W-1:0] w, logic f);
		tok_t t;
		t.code  = c;
		t.width = w;
		t.fin   = f;
		return t;
	endfunction

	assign s_tready = (state_q == ST_ACCEPT) && room;
	assign accept   = s_tvalid && s_tready;

	assign hit     = tbl_rd_data[DATA_W-1 -: EPOCH_BITS] == epoch_q;
	assign rcode   = tbl_rd_data[MAX_CODE_BITS-1:0];
	assign sym_ext = MAX_CODE_BITS'(sym_s1);

	always_comb begin
		w_v   = cw_q;
		nf_v  = nf_q;
		pf_v  = prefix_q;
		inf_v = in_frame_q;
		clr_v = 1'b0;
		wr_v  = 1'b0;
		n_v   = '0;
		tok_v = '0;
		lim_v = '0;
		case (req_s1)
			REQ_PIXEL, REQ_LAST: begin
				if (!inf_v) begin
					tok_v[n_v[1:0]] = mk_tok(HDR_CODE, HDR_W, 1'b0);
					n_v = n_v + 1'b1;
					clr_v = 1'b1;
					nf_v  = FIRST_FREE;
					w_v   = START_W;
					tok_v[n_v[1:0]] = mk_tok(CLEAR_CODE, w_v, 1'b0);
					n_v = n_v + 1'b1;
					pf_v  = sym_ext;
					inf_v = 1'b1;
				end else if (hit) begin
					pf_v = rcode;
				end else begin
					tok_v[n_v[1:0]] = mk_tok(CODE_W'(pf_v), w_v, 1'b0);
					n_v = n_v + 1'b1;
					wr_v = nf_v < CODE_LIMIT;
					nf_v = nf_v + 1'b1;
					lim_v = NF_W'(1) << w_v;
					if (nf_v > lim_v) begin
						if (w_v < MAX_W) begin
							w_v = w_v + 1'b1;
						end else begin
							tok_v[n_v[1:0]] = mk_tok(CLEAR_CODE, w_v, 1'b0);
							n_v = n_v + 1'b1;
							clr_v = 1'b1;
							nf_v  = FIRST_FREE;
							w_v   = START_W;
						end
					end
					pf_v = sym_ext;
				end
				if (req_s1 == REQ_LAST) begin
					tok_v[n_v[1:0]] = mk_tok(CODE_W'(pf_v), w_v, 1'b0);
					n_v = n_v + 1'b1;
					tok_v[n_v[1:0]] = mk_tok(END_CODE, w_v, 1'b1);
					n_v = n_v + 1'b1;
					inf_v = 1'b0;
				end
			end
			REQ_EMPTY: begin
				if (!inf_v) begin
					tok_v[n_v[1:0]] = mk_tok(HDR_CODE, HDR_W, 1'b0);
					n_v = n_v + 1'b1;
					clr_v = 1'b1;
					nf_v  = FIRST_FREE;
					w_v   = START_W;
					tok_v[n_v[1:0]] = mk_tok(CLEAR_CODE, w_v, 1'b0);
					n_v = n_v + 1'b1;
				end else begin
					tok_v[n_v[1:0]] = mk_tok(CODE_W'(pf_v), w_v, 1'b0);
					n_v = n_v + 1'b1;
				end
				tok_v[n_v[1:0]] = mk_tok(END_CODE, w_v, 1'b1);
				n_v = n_v + 1'b1;
				inf_v = 1'b0;
			end
			default: begin
			end
		endcase
	end

	assign wrap = clr_v && (epoch_q == '1);

	always_comb begin
		tbl_req = '0;
		case (state_q)
			ST_SWEEP: begin
				tbl_req.wr_en   = 1'b1;
				tbl_req.wr_addr = ADDR_W_MAX'(sweep_q);
			end
			ST_ACCEPT: begin
				tbl_req.rd_en   = accept;
				tbl_req.rd_addr = ADDR_W_MAX'({prefix_q, s_tdata[SYMBOL_BITS-1:0]});
			end
			ST_DECIDE: begin
				tbl_req.wr_en   = wr_v;
				tbl_req.wr_addr = ADDR_W_MAX'(idx_s1);
				tbl_req.wr_data = DATA_W_MAX'({epoch_q, nf_q[MAX_CODE_BITS-1:0]});
			end
			default: begin
			end
		endcase
	end

	assign push.cnt = (state_q == ST_DECIDE) ? n_v : '0;
	assign push.tok = tok_v;

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= s_tuser;
			sym_s1 <= s_tdata[SYMBOL_BITS-1:0];
			idx_s1 <= {prefix_q, s_tdata[SYMBOL_BITS-1:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_SWEEP;
			sweep_q    <= '0;
			prefix_q   <= '0;
			nf_q       <= FIRST_FREE;
			cw_q       <= START_W;
			in_frame_q <= 1'b0;
			epoch_q    <= EPOCH_FIRST;
		end else begin
			case (state_q)
				ST_SWEEP: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == '1) begin
						state_q <= ST_ACCEPT;
					end
				end
				ST_ACCEPT: begin
					if (accept) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					prefix_q   <= pf_v;
					nf_q       <= nf_v;
					cw_q       <= w_v;
					in_frame_q <= inf_v;
					if (clr_v) begin
						epoch_q <= wrap ? EPOCH_FIRST : epoch_q + 1'b1;
					end
					state_q <= wrap ? ST_SWEEP : ST_ACCEPT;
				end
				default: begin
					state_q <= ST_SWEEP;
				end
			endcase
		end
	end

endmodule

// ----- sv/gle_packer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gle_packer - code token queue and LSB-first bit packer
// Queues code tokens, packs them into bytes, pads and marks the frame's last.
// ----------------------------------------------------------------------------
module gle_packer
	import gle_pkg::*;
#(
	parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  tok_push_t push,
	output logic      room,
	output logic      m_tvalid,
	input  logic      m_tready,
	output logic [7:0] m_tdata,   // out_byte[7:0]
	output logic      m_tlast
);

	localparam int ACC_W  = MAX_CODE_BITS + BYTE_BITS;
	localparam int FILL_W = $clog2(ACC_W + 1);
	localparam int QP_W   = $clog2(QUEUE_DEPTH);
	localparam int QC_W   = $clog2(QUEUE_DEPTH + 1);

	localparam logic [FILL_W-1:0] FILL_BYTE = FILL_W'(BYTE_BITS);
	localparam logic [QC_W-1:0]   ROOM_MAX  = QC_W'(QUEUE_DEPTH - PUSH_MAX);

	tok_t              q_mem [QUEUE_DEPTH];
	logic [QP_W-1:0]   wp_q;
	logic [QP_W-1:0]   rp_q;
	logic [QC_W-1:0]   cnt_q;

	logic [ACC_W-1:0]  acc_q;
	logic [FILL_W-1:0] fill_q;
	logic              fin_q;

	logic              out_free;
	logic              have;
	logic              emit;
	logic [ACC_W-1:0]  acc_e;
	logic [FILL_W-1:0] fill_e;
	logic              fin_e;
	logic              have_e;
	logic              pop;
	tok_t              head;
	logic [ACC_W-1:0]  mask;
	logic [ACC_W-1:0]  acc_p;
	logic [FILL_W-1:0] fill_p;

	assign room     = cnt_q <= ROOM_MAX;
	assign out_free = !m_tvalid || m_tready;
	assign have     = (fill_q >= FILL_BYTE) || (fin_q && (fill_q != '0));
	assign emit     = out_free && have;

	assign acc_e  = emit ? (acc_q >> BYTE_BITS) : acc_q;
	assign fill_e = emit ? ((fill_q >= FILL_BYTE) ? fill_q - FILL_BYTE : '0) : fill_q;
	assign fin_e  = emit ? (fin_q && (fill_q > FILL_BYTE)) : fin_q;
	assign have_e = (fill_e >= FILL_BYTE) || (fin_e && (fill_e != '0));
	assign pop    = !have_e && (cnt_q != '0);

	assign head   = q_mem[rp_q];
	assign mask   = (ACC_W'(1) << head.width) - 1'b1;
	assign acc_p  = acc_e | ((ACC_W'(head.code) & mask) << fill_e);
	assign fill_p = fill_e + FILL_W'(head.width);

	always_ff @(posedge clk) begin
		for (int i = 0; i < PUSH_MAX; i++) begin
			if (PUSH_CNT_W'(i) < push.cnt) begin
				q_mem[wp_q + QP_W'(i)] <= push.tok[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_tdata <= acc_q[7:0];
			m_tlast <= fin_q && (fill_q <= FILL_BYTE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			rp_q     <= '0;
			cnt_q    <= '0;
			acc_q    <= '0;
			fill_q   <= '0;
			fin_q    <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			wp_q  <= wp_q + QP_W'(push.cnt);
			rp_q  <= rp_q + QP_W'(pop);
			cnt_q <= cnt_q + QC_W'(push.cnt) - QC_W'(pop);
			if (pop) begin
				acc_q  <= acc_p;
				fill_q <= fill_p;
				fin_q  <= head.fin;
			end else begin
				acc_q  <= acc_e;
				fill_q <= fill_e;
				fin_q  <= fin_e;
			end
			if (emit) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

endmodule

// ----- sv/gif_lzw_encoder_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gif_lzw_encoder_top - GIF variable-width LZW encoder, 8-bit palette indices
// Input stream: one beat per pixel; s_tuser carries the request type (pixel,
// last pixel of frame, empty frame), s_tdata the palette index. Output stream:
// one beat per code-stream byte, header byte included; m_tlast marks the final
// byte of each frame.
// A pixel beat passes the string-table read, then the hit/miss decision and
// write-back, which the next pixel's prefix depends on.
// A beat's codes reach the output register by way of the token queue and the
// bit accumulator, behind any bytes already queued; the output side moves up
// to one byte per cycle while the receiver takes them.
// A token queue and the output register part the two sides: input beats are
// accepted while output waits, until the queue lacks room for a beat's codes.
// A stalled receiver holds m_tdata and m_tlast until taken.
// After reset all 2^(MAX_CODE_BITS+SYMBOL_BITS) string table entries are swept
// clean (1048576 by default), with s_tready low. The same sweep runs again
// after every 1023 table clears, when the table epoch wraps.
// ----------------------------------------------------------------------------
module gif_lzw_encoder_top
	import gle_pkg::*;
#(
	parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF,
	parameter int SYMBOL_BITS   = SYMBOL_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // pixel_index[7:0]
	input  logic [1:0] s_tuser,   // req_type[1:0]
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // out_byte[7:0]
	output logic       m_tlast
);

	localparam int ADDR_W = MAX_CODE_BITS + SYMBOL_BITS;
	localparam int DATA_W = EPOCH_BITS + MAX_CODE_BITS;

	tbl_req_t          tbl_req;
	logic [DATA_W-1:0] tbl_rd_data;
	tok_push_t         push;
	logic              room;

	gle_table #(
		.ADDR_W (ADDR_W),
		.DATA_W (DATA_W)
	) u_table (
		.clk     (clk),
		.req     (tbl_req),
		.rd_data (tbl_rd_data)
	);

	gle_core #(
		.MAX_CODE_BITS (MAX_CODE_BITS),
		.SYMBOL_BITS   (SYMBOL_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.tbl_req     (tbl_req),
		.tbl_rd_data (tbl_rd_data),
		.push        (push),
		.room        (room)
	);

	gle_packer #(
		.MAX_CODE_BITS (MAX_CODE_BITS)
	) u_packer (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (room),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
